[hdl/asfx_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// asfx_pkg
// Shared types, codes and reset values of the sound effect sequencer.
// -----------------------------------------------------------------------------
package asfx_pkg;

    localparam int TICK_W  = 20;
    localparam int CIDX_W  = 3;

    // item operations
    localparam logic [1:0] OP_EFFECT  = 2'd0;
    localparam logic [1:0] OP_CONTROL = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_COCKTAIL = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_FAST     = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_MEDIUM   = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SLOW     = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_LOW      = 3'd4;

    localparam logic [TICK_W-1:0] RST_FAST   = 20'd31056;
    localparam logic [TICK_W-1:0] RST_MEDIUM = 20'd52351;
    localparam logic [TICK_W-1:0] RST_SLOW   = 20'd90505;
    localparam logic [TICK_W-1:0] RST_LOW    = 20'd13860;

    // sequencer phases
    localparam logic [2:0] PH_OFF   = 3'd0;
    localparam logic [2:0] PH_ONE   = 3'd1;
    localparam logic [2:0] PH_TWO   = 3'd2;
    localparam logic [2:0] PH_THREE = 3'd3;
    localparam logic [2:0] PH_FOUR  = 3'd4;
    localparam logic [2:0] PH_PAUSE = 3'd5;

    // effect codes
    localparam logic [2:0] EFF_NONE   = 3'd0;
    localparam logic [2:0] EFF_FAST   = 3'd1;
    localparam logic [2:0] EFF_MEDIUM = 3'd2;
    localparam logic [2:0] EFF_SLOW   = 3'd4;

    // effect port byte mask and patterns
    localparam logic [7:0] SEQ_MASK   = 8'h2c;
    localparam logic [7:0] SEQ_TO_TWO = 8'h28;
    localparam logic [7:0] SEQ_TO_THR = 8'h24;
    localparam logic [7:0] SEQ_TO_FOU = 8'h2c;
    localparam logic [7:0] SEQ_QUIET  = 8'h00;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic       tone_enable;
        logic       explosion_mode;
        logic       dot_enable;
        logic       music_bit;
        logic       sound_on;
        logic       coin_lock;
        logic       flip_screen;
        logic [2:0] effect_code;
        logic       timer_low;
        logic [2:0] sequence_phase;
    } t_out_item;

    typedef struct packed {
        logic              cocktail;
        logic [TICK_W-1:0] fast;
        logic [TICK_W-1:0] mid;
        logic [TICK_W-1:0] slow;
        logic [TICK_W-1:0] low;
    } t_cfg;

    function automatic logic [TICK_W-1:0] high_time(input logic [2:0] eff, input t_cfg cfg);
        logic [TICK_W-1:0] t;
        if (eff == EFF_FAST) begin
            t = cfg.fast;
        end else if (eff == EFF_MEDIUM) begin
            t = cfg.mid;
        end else begin
            t = cfg.slow;
        end
        return t;
    endfunction

    function automatic logic [2:0] phase_effect(input logic [2:0] ph);
        logic [2:0] e;
        unique case (ph)
            PH_ONE:   e = EFF_SLOW;
            PH_TWO:   e = EFF_MEDIUM;
            PH_THREE: e = EFF_FAST;
            default:  e = EFF_NONE;
        endcase
        return e;
    endfunction

endpackage

[hdl/asfx_core.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// asfx_core
// Sequencer and 555 timer state; computes the result of the item being taken.
// -----------------------------------------------------------------------------
module asfx_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  asfx_pkg::t_in_item   i_item,
    input  asfx_pkg::t_cfg       i_cfg,
    output asfx_pkg::t_out_item  o_result
);
    import asfx_pkg::*;

    logic [2:0]        r_phase,     n_phase;
    logic              r_explosion, n_explosion;
    logic              r_dot,       n_dot;
    logic              r_sound,     n_sound;
    logic              r_music,     n_music;
    logic              r_coin,      n_coin;
    logic              r_flip,      n_flip;
    logic [2:0]        r_last,      n_last;
    logic              r_low,       n_low;
    logic              r_running,   n_running;
    logic [2:0]        r_teff,      n_teff;
    logic [TICK_W-1:0] r_count,     n_count;

    logic [7:0] masked;
    logic [2:0] eff;

    always_comb begin
        n_phase     = r_phase;
        n_explosion = r_explosion;
        n_dot       = r_dot;
        n_sound     = r_sound;
        n_music     = r_music;
        n_coin      = r_coin;
        n_flip      = r_flip;
        n_last      = r_last;
        n_low       = r_low;
        n_running   = r_running;
        n_teff      = r_teff;
        n_count     = r_count;
        masked      = i_item.data & SEQ_MASK;
        eff         = EFF_NONE;

        unique case (i_item.op)
            OP_EFFECT: begin
                n_explosion = i_item.data[4];
                if (!i_item.data[4]) begin
                    n_dot = i_item.data[1];
                end
                priority if (!r_sound) begin
                    n_phase = PH_OFF;
                end else if (r_phase == PH_OFF) begin
                    n_phase = PH_ONE;
                end else if (r_phase == PH_ONE && masked == SEQ_TO_TWO) begin
                    n_phase = PH_TWO;
                end else if (r_phase == PH_TWO && masked == SEQ_TO_THR) begin
                    n_phase = PH_THREE;
                end else if (r_phase < PH_FOUR && masked == SEQ_TO_FOU) begin
                    n_phase = PH_FOUR;
                end else if (r_phase > PH_TWO && masked == SEQ_QUIET) begin
                    n_phase = PH_PAUSE;
                end else begin
                    n_phase = r_phase;
                end
                eff = phase_effect(n_phase);
                // the timer only reacts to a change while in its high phase
                if (r_last != eff) begin
                    if (!r_low) begin
                        if (eff != EFF_NONE) begin
                            n_running = 1'b1;
                            n_teff    = eff;
                            n_count   = high_time(eff, i_cfg);
                        end else begin
                            n_running = 1'b0;
                        end
                    end
                    n_last = eff;
                end
            end
            OP_CONTROL: begin
                n_music = i_item.data[0];
                n_coin  = i_item.data[2];
                n_sound = i_item.data[4];
                n_flip  = i_item.data[5] & i_cfg.cocktail;
            end
            OP_TICK: begin
                if (r_running) begin
                    if (r_count > TICK_W'(1)) begin
                        n_count = r_count - TICK_W'(1);
                    end else begin
                        n_low = !r_low;
                        if (!r_low) begin
                            n_count = i_cfg.low;
                        end else if (r_teff != EFF_NONE) begin
                            n_count = high_time(r_teff, i_cfg);
                        end else begin
                            n_running = 1'b0;
                            n_count   = '0;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_OFF;
            r_explosion <= 1'b0;
            r_dot       <= 1'b0;
            r_sound     <= 1'b0;
            r_music     <= 1'b0;
            r_coin      <= 1'b0;
            r_flip      <= 1'b0;
            r_last      <= EFF_NONE;
            r_low       <= 1'b0;
            r_running   <= 1'b0;
            r_teff      <= EFF_NONE;
            r_count     <= '0;
        end else if (i_load) begin
            r_phase     <= n_phase;
            r_explosion <= n_explosion;
            r_dot       <= n_dot;
            r_sound     <= n_sound;
            r_music     <= n_music;
            r_coin      <= n_coin;
            r_flip      <= n_flip;
            r_last      <= n_last;
            r_low       <= n_low;
            r_running   <= n_running;
            r_teff      <= n_teff;
            r_count     <= n_count;
        end
    end

    always_comb begin
        o_result.tone_enable    = !(n_low | n_explosion);
        o_result.explosion_mode = n_explosion;
        o_result.dot_enable     = n_dot;
        o_result.music_bit      = n_music;
        o_result.sound_on       = n_sound;
        o_result.coin_lock      = n_coin;
        o_result.flip_screen    = n_flip;
        o_result.effect_code    = n_last;
        o_result.timer_low      = n_low;
        o_result.sequence_phase = n_phase;
    end

endmodule

[hdl/arcade_sound_effect_sequencer.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// arcade_sound_effect_sequencer
// Sound-control ports: effect sequencer, 555 timer model and control bits.
// -----------------------------------------------------------------------------
//  channel  | signals                                   | notes
//  ---------+-------------------------------------------+----------------------
//  input    | i_in_valid, o_in_ready, i_in_item         | op + data byte
//  output   | o_out_valid, i_out_ready, o_out_item      | one result per item
//  config   | i_cfg_we, i_cfg_index, i_cfg_data         | write only, no wait
//
//  One item per cycle while no result is stalled; its result shows in the
//  cycle after the transfer, from the result register that follows the
//  single pass of state-update logic. Reset is synchronous, active low; it
//  clears state and restores the timing registers. A stalled result holds;
//  a new item is still taken in the cycle the stalled result leaves.
// -----------------------------------------------------------------------------
module arcade_sound_effect_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  asfx_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output asfx_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_we,
    input  logic [asfx_pkg::CIDX_W-1:0]      i_cfg_index,
    input  logic [asfx_pkg::TICK_W-1:0]      i_cfg_data
);
    import asfx_pkg::*;

    t_cfg      r_cfg;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      r_out_valid;
    logic      load;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign load       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cocktail <= 1'b0;
            r_cfg.fast     <= RST_FAST;
            r_cfg.mid      <= RST_MEDIUM;
            r_cfg.slow     <= RST_SLOW;
            r_cfg.low      <= RST_LOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COCKTAIL: r_cfg.cocktail <= i_cfg_data[0];
                CFG_FAST:     r_cfg.fast     <= i_cfg_data;
                CFG_MEDIUM:   r_cfg.mid      <= i_cfg_data;
                CFG_SLOW:     r_cfg.slow     <= i_cfg_data;
                CFG_LOW:      r_cfg.low      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    asfx_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_item   (i_in_item),
        .i_cfg    (r_cfg),
        .o_result (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[hdl/asfx_chk.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// asfx_chk
// Port-level checks of the sound effect sequencer, bound to the top level.
// -----------------------------------------------------------------------------
module asfx_chk (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  asfx_pkg::t_out_item  o_out_item
);
    import asfx_pkg::*;

    // every transfer in shows up as a result on the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("input transfer produced no result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.tone_enable ==
                        !(o_out_item.timer_low | o_out_item.explosion_mode))
        else $error("tone enable inconsistent with timer and explosion");

    // effect code always tracks the sequencer phase
    a_effect_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.effect_code ==
                        phase_effect(o_out_item.sequence_phase))
        else $error("effect code does not match phase");

endmodule

bind arcade_sound_effect_sequencer asfx_chk u_asfx_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
